>>> hw/rtl/partitioned_multi_queue_assert.svh
// ----------------------------------------------------------------------------
// Partitioned multi-queue assertion macros
// Property macros used by the checker of the partitioned multi-queue.
// ----------------------------------------------------------------------------
`ifndef PARTITIONED_MULTI_QUEUE_ASSERT_SVH
`define PARTITIONED_MULTI_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define PMQ_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("partitioned multi-queue check failed");

// Next-cycle implication, sampled on aclk and disabled during reset.
`define PMQ_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("partitioned multi-queue check failed");

`endif

>>> hw/rtl/pmq_pkg.sv
// ----------------------------------------------------------------------------
// Partitioned multi-queue package
// Sizes, codes, beat payload types and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pmq_pkg;

    localparam int NUM_QUEUES    = 4;
    localparam int STORAGE_DEPTH = 128;

    localparam int DATA_W    = 32;
    localparam int QIDX_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int ADDR_W    = $clog2(STORAGE_DEPTH);
    localparam int CNT_W     = 8;
    localparam int SUM_W     = CNT_W + QIDX_W;
    localparam int BASE_W    = (SUM_W > ADDR_W + 1) ? SUM_W : ADDR_W + 1;
    localparam int DIV_W     = CNT_W + 1;
    localparam int SHIFT_W   = DIV_W + CNT_W;
    localparam int STEP_W    = $clog2(DIV_W);
    localparam int CFG_IDX_W = 8;

    localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'(32);

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] STS_DONE  = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    typedef struct packed {
        logic                     cmd;
        logic [1:0]               queue_id;
        logic signed [DATA_W-1:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] pop_value;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        logic load_queue;
        logic mod_step;
        logic mem_access;
        logic out_load;
    } pmq_cmd_t;

    typedef struct packed {
        logic go;
        logic mod_done;
    } pmq_stat_t;

endpackage

>>> hw/rtl/pmq_ctrl.sv
// ----------------------------------------------------------------------------
// Partitioned multi-queue controller
// Sequences one item through lookup, then remainder steps and storage access
// if the lookup lets it go on, then the result register; owns the beat handshakes.
// ----------------------------------------------------------------------------
module pmq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  pmq_pkg::pmq_stat_t  stat,
    output pmq_pkg::pmq_cmd_t   cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_MOD  = 5'b00100,
        ST_MEM  = 5'b01000,
        ST_RES  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        cmd            = '0;
        cmd.load_item  = (state_reg == ST_IDLE) && s_valid;
        cmd.load_queue = (state_reg == ST_LOAD);
        cmd.mod_step   = (state_reg == ST_MOD);
        cmd.mem_access = (state_reg == ST_MEM);
        cmd.out_load   = (state_reg == ST_RES) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = stat.go ? ST_MOD : ST_RES;
            end
            ST_MOD: begin
                if (stat.mod_done) begin
                    state_next = ST_MEM;
                end
            end
            ST_MEM: begin
                state_next = ST_RES;
            end
            ST_RES: begin
                if (cmd.out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

>>> hw/rtl/pmq_datapath.sv
// ----------------------------------------------------------------------------
// Partitioned multi-queue datapath
// Size registers, per-queue head and fill state, region lookup, a bit-serial
// remainder unit, the shared entry storage and the result register.
// ----------------------------------------------------------------------------
module pmq_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pmq_pkg::in_item_t                s_data,
    input  logic                             cfg_valid,
    input  logic [pmq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pmq_pkg::CNT_W-1:0]        cfg_data,
    input  pmq_pkg::pmq_cmd_t                cmd,
    output pmq_pkg::pmq_stat_t               stat,
    output pmq_pkg::out_item_t               m_data
);

    localparam logic [pmq_pkg::BASE_W-1:0] DEPTH_B =
        pmq_pkg::BASE_W'(pmq_pkg::STORAGE_DEPTH);

    logic [pmq_pkg::CNT_W-1:0]  size_reg [pmq_pkg::NUM_QUEUES];
    logic [pmq_pkg::CNT_W-1:0]  head_reg [pmq_pkg::NUM_QUEUES];
    logic [pmq_pkg::CNT_W-1:0]  fill_reg [pmq_pkg::NUM_QUEUES];
    logic [pmq_pkg::DATA_W-1:0] mem [pmq_pkg::STORAGE_DEPTH];

    pmq_pkg::in_item_t          item_reg;
    pmq_pkg::out_item_t         m_data_reg;
    logic [pmq_pkg::ADDR_W-1:0] base_reg;
    logic [pmq_pkg::CNT_W-1:0]  cap_reg;
    logic [pmq_pkg::DIV_W-1:0]  rem_reg;
    logic [pmq_pkg::DIV_W-1:0]  rem_next;
    logic [pmq_pkg::STEP_W-1:0] step_reg;
    logic [1:0]                 sts_reg;
    logic                       go_reg;
    logic [pmq_pkg::DATA_W-1:0] rdata_reg;

    logic                        q_valid;
    logic [pmq_pkg::QIDX_W-1:0]  qidx;
    logic [pmq_pkg::BASE_W-1:0]  base_sum;
    logic [pmq_pkg::BASE_W-1:0]  room;
    logic [pmq_pkg::CNT_W-1:0]   cap_calc;
    logic [pmq_pkg::CNT_W-1:0]   fill_cur;
    logic [pmq_pkg::CNT_W-1:0]   head_cur;
    logic [1:0]                  sts_calc;
    logic                        go_calc;
    logic                        zero_cap_pop;
    logic [pmq_pkg::DIV_W-1:0]   dividend;
    logic [pmq_pkg::SHIFT_W-1:0] divisor_sh;
    logic [pmq_pkg::SHIFT_W-1:0] rem_ext;
    logic [pmq_pkg::ADDR_W-1:0]  mem_addr;
    logic [pmq_pkg::DIV_W-1:0]   pos_inc;
    logic [pmq_pkg::CNT_W-1:0]   head_wrap;
    logic                        is_deq;
    logic [pmq_pkg::DATA_W-1:0]  pop;

    assign q_valid = (int'(item_reg.queue_id) < pmq_pkg::NUM_QUEUES);
    assign qidx    = pmq_pkg::QIDX_W'(item_reg.queue_id);
    assign is_deq  = (item_reg.cmd == pmq_pkg::CMD_DEQ);

    always_comb begin
        base_sum = '0;
        for (int i = 0; i < pmq_pkg::NUM_QUEUES; i++) begin
            if (i < int'(qidx)) begin
                base_sum = base_sum + pmq_pkg::BASE_W'(size_reg[i]);
            end
        end
        room = DEPTH_B - base_sum;
        if (base_sum >= DEPTH_B) begin
            cap_calc = '0;
        end else if (pmq_pkg::BASE_W'(size_reg[qidx]) < room) begin
            cap_calc = size_reg[qidx];
        end else begin
            cap_calc = pmq_pkg::CNT_W'(room);
        end
    end

    always_comb begin
        fill_cur     = fill_reg[qidx];
        head_cur     = head_reg[qidx];
        sts_calc     = pmq_pkg::STS_DONE;
        go_calc      = 1'b0;
        zero_cap_pop = 1'b0;
        dividend     = '0;
        if (!q_valid) begin
            sts_calc = is_deq ? pmq_pkg::STS_EMPTY : pmq_pkg::STS_FULL;
        end else if (!is_deq) begin
            if (fill_cur >= cap_calc) begin
                sts_calc = pmq_pkg::STS_FULL;
            end else begin
                go_calc  = 1'b1;
                dividend = pmq_pkg::DIV_W'(head_cur) + pmq_pkg::DIV_W'(fill_cur);
            end
        end else if (fill_cur == '0) begin
            sts_calc = pmq_pkg::STS_EMPTY;
        end else if (cap_calc == '0) begin
            zero_cap_pop = 1'b1;
        end else begin
            go_calc  = 1'b1;
            dividend = pmq_pkg::DIV_W'(head_cur);
        end
    end

    always_comb begin
        divisor_sh = pmq_pkg::SHIFT_W'(cap_reg) << step_reg;
        rem_ext    = pmq_pkg::SHIFT_W'(rem_reg);
        rem_next   = rem_reg;
        if (rem_ext >= divisor_sh) begin
            rem_next = pmq_pkg::DIV_W'(rem_ext - divisor_sh);
        end
    end

    assign mem_addr  = base_reg + pmq_pkg::ADDR_W'(rem_reg);
    assign pos_inc   = rem_reg + pmq_pkg::DIV_W'(1);
    assign head_wrap = (pos_inc == pmq_pkg::DIV_W'(cap_reg)) ? '0 : pmq_pkg::CNT_W'(pos_inc);
    assign pop       = (go_reg && is_deq) ? rdata_reg : '0;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < pmq_pkg::NUM_QUEUES; i++) begin
            if (!aresetn) begin
                size_reg[i] <= pmq_pkg::SIZE_RESET;
            end else if (cfg_valid && (cfg_index == pmq_pkg::CFG_IDX_W'(i))) begin
                size_reg[i] <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pmq_pkg::NUM_QUEUES; i++) begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else if (cmd.load_queue && zero_cap_pop) begin
            fill_reg[qidx] <= fill_cur - pmq_pkg::CNT_W'(1);
            head_reg[qidx] <= '0;
        end else if (cmd.mem_access) begin
            if (is_deq) begin
                fill_reg[qidx] <= fill_cur - pmq_pkg::CNT_W'(1);
                head_reg[qidx] <= head_wrap;
            end else begin
                fill_reg[qidx] <= fill_cur + pmq_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        if (cmd.load_queue) begin
            base_reg <= pmq_pkg::ADDR_W'(base_sum);
            cap_reg  <= cap_calc;
            rem_reg  <= dividend;
            step_reg <= pmq_pkg::STEP_W'(pmq_pkg::DIV_W - 1);
            sts_reg  <= sts_calc;
            go_reg   <= go_calc;
        end else if (cmd.mod_step) begin
            rem_reg  <= rem_next;
            step_reg <= step_reg - pmq_pkg::STEP_W'(1);
        end
        if (cmd.out_load) begin
            m_data_reg.status    <= sts_reg;
            m_data_reg.pop_value <= pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_access && !is_deq) begin
            mem[mem_addr] <= item_reg.push_value;
        end
        if (cmd.mem_access && is_deq) begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign stat.go       = go_calc;
    assign stat.mod_done = (step_reg == '0);
    assign m_data        = m_data_reg;

endmodule

>>> hw/rtl/partitioned_multi_queue.sv
// An item is taken in and looked up; if it reads or writes the storage, it then
// passes through the 9-step bit-serial remainder unit that places the ring position
// and the storage access before its result beat, else it goes straight to the result.
// No new item is taken until the previous item's result is loaded for output.
// Reset (aresetn low, synchronous) empties every queue and sets each size to 32;
// the entry storage is not cleared.
// ----------------------------------------------------------------------------
// Partitioned multi-queue
// Several FIFO queues sharing one storage array, each in its own region.
// ----------------------------------------------------------------------------
module partitioned_multi_queue (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  pmq_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output pmq_pkg::out_item_t               m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pmq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pmq_pkg::CNT_W-1:0]        cfg_data
);

    pmq_pkg::pmq_cmd_t  cmd;
    pmq_pkg::pmq_stat_t stat;

    assign cfg_ready = 1'b1;

    pmq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pmq_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule

>>> hw/rtl/pmq_checker.sv
// ----------------------------------------------------------------------------
// Partitioned multi-queue checker
// Port-level properties of the partitioned multi-queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "partitioned_multi_queue_assert.svh"

module pmq_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input pmq_pkg::out_item_t m_data
);

    logic status_known;
    logic status_failed;

    assign status_known  = (m_data.status == pmq_pkg::STS_DONE)
                        || (m_data.status == pmq_pkg::STS_EMPTY)
                        || (m_data.status == pmq_pkg::STS_FULL);
    assign status_failed = (m_data.status != pmq_pkg::STS_DONE);

    `PMQ_ASSERT_NXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_data))
    `PMQ_ASSERT_NXT(a_one_item_at_a_time, s_valid && s_ready, !s_ready)
    `PMQ_ASSERT_IMP(a_status_code, m_valid, status_known)
    `PMQ_ASSERT_IMP(a_fail_pops_zero, m_valid && status_failed, m_data.pop_value == '0)

endmodule

bind partitioned_multi_queue pmq_checker u_pmq_checker (.*);
